FILE: rtl/core/frame_rate_and_timing_monitor_assert.svh
// Assertion helpers shared by the frame rate monitor RTL.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef FRAME_RATE_AND_TIMING_MONITOR_ASSERT_SVH
`define FRAME_RATE_AND_TIMING_MONITOR_ASSERT_SVH

// Same-cycle implication.
`define FRATM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame rate monitor check failed");

// Next-cycle implication.
`define FRATM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame rate monitor check failed");

`endif

FILE: rtl/core/fratm_pkg.sv
`timescale 1ns / 1ps
package fratm_pkg;

  localparam int unsigned DIV_W   = 64;
  localparam int unsigned DIV_CW  = $clog2(DIV_W);
  localparam int unsigned SCALE_W = 24;

  // rate scale: tenths of a frame per second from microseconds
  localparam logic [SCALE_W-1:0] RATE_SCALE   = SCALE_W'(10000000);
  localparam logic [31:0]        WINDOW_RESET = 32'd1000000;

  typedef enum logic [1:0] {
    OP_FRAME  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_STOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_COMMIT,
    ST_OUT
  } state_e;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    logic [31:0] r;
    r = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
    return r;
  endfunction

endpackage

FILE: rtl/core/fratm_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module fratm_div import fratm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  logic              busy_q;
  logic              done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DIV_W-1:0]  rem_q;
  logic [DIV_W-1:0]  dsr_q;

  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    diff;
  logic              take;

  always_comb begin
    shifted = {rem_q, quo_q[DIV_W-1]};
    diff    = shifted - {1'b0, dsr_q};
    take    = !diff[DIV_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/core/frame_rate_and_timing_monitor.sv
// Sequence, accept to result valid: a frame request passes through multiply, operand load,
//   the bit-serial dividers, done, commit and result load; a timing sample skips the multiply.
//   Reset-counters and mark-stopped requests go straight to the result load.
// Flow: one request in flight; the next is accepted the cycle after the result loads,
//   and that load waits while an earlier result sits stalled.
// Reset (rst_ni low, async): stats zero, not running, window 1000000 us, no result pending.
`timescale 1ns / 1ps
`include "frame_rate_and_timing_monitor_assert.svh"
module frame_rate_and_timing_monitor import fratm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] timestamp_us_i,
  input  logic [31:0] compose_time_us_i,
  input  logic [31:0] present_time_us_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] current_rate_x10_o,
  output logic [31:0] average_rate_x10_o,
  output logic [31:0] frames_seen_o,
  output logic [31:0] compose_mean_us_o,
  output logic [31:0] compose_peak_us_o,
  output logic [31:0] present_mean_us_o,
  output logic [31:0] present_peak_us_o,
  output logic        window_closed_o
);

  // ---------------------------------------------------------------------------
  // Configuration: one register, window length, at byte address 0.
  // ---------------------------------------------------------------------------
  logic [31:0] window_len_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : window_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= WINDOW_RESET;
    end else if (cfg_wr) begin
      window_len_q <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Control FSM
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;
  logic   accept;
  logic   div_start;
  logic   out_load;
  logic   out_valid_q;
  logic   div0_done, div1_done;
  op_e    op_q;

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (op_e'(operation_i))
            OP_FRAME:  state_d = ST_MUL;
            OP_SAMPLE: state_d = ST_LOAD;
            default:   state_d = ST_OUT;
          endcase
        end
      end
      ST_MUL:  state_d = ST_LOAD;
      ST_LOAD: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div0_done) state_d = ST_COMMIT;
      end
      ST_COMMIT: state_d = ST_OUT;
      ST_OUT: begin
        // result register frees up when empty or being taken this cycle
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor state
  // ---------------------------------------------------------------------------
  logic        running_q;
  logic [63:0] start_q, wstart_q;
  logic [31:0] frame_total_q, wframes_q;
  logic [31:0] window_rate_q, overall_rate_q;
  logic [63:0] compose_sum_q, present_sum_q;
  logic [31:0] sample_cnt_q;
  logic [31:0] compose_max_q, present_max_q;
  logic [31:0] compose_mean_q, present_mean_q;
  logic        closed_q;

  // request payload and frame working registers
  logic [63:0]           now_q;
  logic [63:0]           elapsed_all_q, elapsed_win_q;
  logic [SCALE_W+31:0]   prod_all_q, prod_win_q;
  logic [DIV_W-1:0]      div0_dividend, div0_divisor, div1_dividend, div1_divisor;
  logic [DIV_W-1:0]      div0_quo, div1_quo;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= timestamp_us_i;
    end
    if (state_q == ST_MUL) begin
      elapsed_all_q <= now_q - start_q;
      elapsed_win_q <= now_q - wstart_q;
      prod_all_q    <= frame_total_q * RATE_SCALE;
      prod_win_q    <= wframes_q * RATE_SCALE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q           <= OP_FRAME;
      running_q      <= 1'b0;
      start_q        <= '0;
      wstart_q       <= '0;
      frame_total_q  <= '0;
      wframes_q      <= '0;
      window_rate_q  <= '0;
      overall_rate_q <= '0;
      compose_sum_q  <= '0;
      present_sum_q  <= '0;
      sample_cnt_q   <= '0;
      compose_max_q  <= '0;
      present_max_q  <= '0;
      compose_mean_q <= '0;
      present_mean_q <= '0;
      closed_q       <= 1'b0;
    end else begin
      if (accept) begin
        op_q     <= op_e'(operation_i);
        closed_q <= 1'b0;
        case (op_e'(operation_i))
          OP_FRAME: begin
            if (!running_q) begin
              // frame while stopped restarts everything at this timestamp
              running_q      <= 1'b1;
              start_q        <= timestamp_us_i;
              wstart_q       <= timestamp_us_i;
              frame_total_q  <= 32'd1;
              wframes_q      <= 32'd1;
              window_rate_q  <= '0;
              overall_rate_q <= '0;
              compose_sum_q  <= '0;
              present_sum_q  <= '0;
              sample_cnt_q   <= '0;
              compose_max_q  <= '0;
              present_max_q  <= '0;
              compose_mean_q <= '0;
              present_mean_q <= '0;
            end else begin
              frame_total_q <= frame_total_q + 32'd1;
              wframes_q     <= wframes_q + 32'd1;
            end
          end
          OP_SAMPLE: begin
            compose_sum_q <= compose_sum_q + {32'd0, compose_time_us_i};
            present_sum_q <= present_sum_q + {32'd0, present_time_us_i};
            sample_cnt_q  <= sample_cnt_q + 32'd1;
            if (compose_time_us_i > compose_max_q) compose_max_q <= compose_time_us_i;
            if (present_time_us_i > present_max_q) present_max_q <= present_time_us_i;
          end
          OP_CLEAR: begin
            running_q      <= 1'b1;
            start_q        <= timestamp_us_i;
            wstart_q       <= timestamp_us_i;
            frame_total_q  <= '0;
            wframes_q      <= '0;
            window_rate_q  <= '0;
            overall_rate_q <= '0;
            compose_sum_q  <= '0;
            present_sum_q  <= '0;
            sample_cnt_q   <= '0;
            compose_max_q  <= '0;
            present_max_q  <= '0;
            compose_mean_q <= '0;
            present_mean_q <= '0;
          end
          default: running_q <= 1'b0;
        endcase
      end

      // window check: closes once the time since the window start reaches the window length
      if (state_q == ST_LOAD && op_q == OP_FRAME) begin
        closed_q <= elapsed_win_q >= {32'd0, window_len_q};
      end

      if (state_q == ST_COMMIT) begin
        case (op_q)
          OP_FRAME: begin
            overall_rate_q <= (elapsed_all_q == 64'd0) ? 32'd0 : sat32(div0_quo);
            if (closed_q) begin
              window_rate_q <= (elapsed_win_q == 64'd0) ? 32'd0 : sat32(div1_quo);
              wframes_q     <= '0;
              wstart_q      <= now_q;
            end
          end
          OP_SAMPLE: begin
            // count wrapped to zero means no mean
            compose_mean_q <= (sample_cnt_q == 32'd0) ? 32'd0 : sat32(div0_quo);
            present_mean_q <= (sample_cnt_q == 32'd0) ? 32'd0 : sat32(div1_quo);
          end
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Divider operands: rounded rate for frames, means for timing samples.
  // rate = (frames * 1e7 + elapsed/2) / elapsed, which stays below 2^64.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (op_q == OP_FRAME) begin
      div0_dividend = DIV_W'(prod_all_q) + (elapsed_all_q >> 1);
      div0_divisor  = elapsed_all_q;
      div1_dividend = DIV_W'(prod_win_q) + (elapsed_win_q >> 1);
      div1_divisor  = elapsed_win_q;
    end else begin
      div0_dividend = compose_sum_q;
      div0_divisor  = {32'd0, sample_cnt_q};
      div1_dividend = present_sum_q;
      div1_divisor  = {32'd0, sample_cnt_q};
    end
  end

  fratm_div u_div0 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div0_dividend),
    .divisor_i  (div0_divisor),
    .done_o     (div0_done),
    .quotient_o (div0_quo)
  );

  fratm_div u_div1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div1_dividend),
    .divisor_i  (div1_divisor),
    .done_o     (div1_done),
    .quotient_o (div1_quo)
  );

  // ---------------------------------------------------------------------------
  // Result register: decouples the result from the next request.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      current_rate_x10_o <= window_rate_q;
      average_rate_x10_o <= overall_rate_q;
      frames_seen_o      <= frame_total_q;
      compose_mean_us_o  <= compose_mean_q;
      compose_peak_us_o  <= compose_max_q;
      present_mean_us_o  <= present_mean_q;
      present_peak_us_o  <= present_max_q;
      window_closed_o    <= closed_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `FRATM_ASSERT_NEXT(a_accept_then_busy, in_valid_i && !in_stall_o, in_stall_o)
  `FRATM_ASSERT_NOW(a_closed_only_frame, state_q == ST_OUT && closed_q, op_q == OP_FRAME)
  `FRATM_ASSERT_NOW(a_div_lockstep, div0_done, div1_done && state_q == ST_DIV)
  `FRATM_ASSERT_NEXT(a_clear_runs, accept && operation_i == OP_CLEAR, running_q)

endmodule
